>>> rtl/http_header_tokenizer_unit_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef HTTP_HEADER_TOKENIZER_UNIT_DEFINES_SVH
`define HTTP_HEADER_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is active
`define HTTOK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, switched off while reset is active
`define HTTOK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

>>> rtl/httok_pkg.sv
// Shared types and constants of the HTTP header tokenizer.
// No dependencies; used by httok_parser and the top level.
package httok_pkg;

  // Configuration register indexes
  localparam logic CfgRespMode = 1'b0;
  localparam logic CfgMaxLen   = 1'b1;

  localparam logic [7:0] MaxLenReset = 8'd128;

  // Parser state codes
  localparam logic [3:0] StFirst  = 4'd0;
  localparam logic [3:0] StSecond = 4'd1;
  localparam logic [3:0] StThirdR = 4'd2;
  localparam logic [3:0] StThirdN = 4'd3;
  localparam logic [3:0] StKey    = 4'd4;
  localparam logic [3:0] StValueR = 4'd5;
  localparam logic [3:0] StValueN = 4'd6;
  localparam logic [3:0] StEndR   = 4'd7;
  localparam logic [3:0] StBody   = 4'd8;

  // Field kinds
  localparam logic [2:0] FkNone    = 3'd0;
  localparam logic [2:0] FkMethod  = 3'd1;
  localparam logic [2:0] FkPath    = 3'd2;
  localparam logic [2:0] FkVersion = 3'd3;
  localparam logic [2:0] FkStatus  = 3'd4;
  localparam logic [2:0] FkText    = 3'd5;
  localparam logic [2:0] FkKey     = 3'd6;
  localparam logic [2:0] FkValue   = 3'd7;

  // Outcomes
  localparam logic [1:0] OcBusy   = 2'd0;
  localparam logic [1:0] OcDone   = 2'd1;
  localparam logic [1:0] OcBody   = 2'd2;
  localparam logic [1:0] OcFailed = 2'd3;

  // Failure causes
  localparam logic [2:0] FcNone      = 3'd0;
  localparam logic [2:0] FcLineEnd   = 3'd1;
  localparam logic [2:0] FcTooLong   = 3'd2;
  localparam logic [2:0] FcBadMethod = 3'd3;
  localparam logic [2:0] FcEmptyPath = 3'd4;

  // Characters
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [2:0] MethodLen = 3'd4;

  // One result item
  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        byte_kept;
    logic [2:0]  field_kind;
    logic        field_end;
    logic [15:0] status_code;
    logic [1:0]  outcome;
    logic [2:0]  fail_cause;
  } res_t;

  // Expected method bytes, in order
  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h50;
      2'd1:    c = 8'h4F;
      2'd2:    c = 8'h53;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/httok_parser.sv
// Header parse state and per-byte tagging logic of the tokenizer.
// Depends on httok_pkg. State advances on every accepted item.
module httok_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic                kind_i,
  input  logic [7:0]          data_byte_i,
  input  logic                resp_mode_i,
  input  logic [7:0]          max_len_i,
  output httok_pkg::res_t     res_o
);

  logic [3:0]  state_q, state_d;
  logic [7:0]  len_q, len_d;
  logic        started_q, started_d;
  logic [2:0]  midx_q, midx_d;
  logic        mmis_q, mmis_d;
  logic [15:0] acc_q, acc_d;
  logic        digdone_q, digdone_d;
  logic        failed_q, failed_d;
  logic [2:0]  cause_q, cause_d;

  logic [19:0] prod;
  logic        is_digit;
  logic [2:0]  fk;
  logic        do_buf, do_close, do_fail;
  logic [2:0]  fail_code;
  logic [3:0]  close_next;
  logic [1:0]  oc;

  assign is_digit = (data_byte_i >= httok_pkg::ChZero) && (data_byte_i <= httok_pkg::ChNine);
  assign prod = {4'd0, acc_q} * 20'd10 + {12'd0, data_byte_i - httok_pkg::ChZero};

  // Decide what this byte does
  always_comb begin
    fk = httok_pkg::FkNone;
    do_buf = 1'b0;
    do_close = 1'b0;
    do_fail = 1'b0;
    fail_code = httok_pkg::FcNone;
    close_next = state_q;
    oc = httok_pkg::OcBusy;
    state_d = state_q;
    if (kind_i) begin
      state_d = httok_pkg::StFirst;
    end else if (failed_q) begin
      oc = httok_pkg::OcFailed;
    end else if (state_q >= httok_pkg::StBody) begin
      oc = httok_pkg::OcBody;
    end else if (!resp_mode_i && (len_q >= max_len_i)) begin
      do_fail = 1'b1;
      fail_code = httok_pkg::FcTooLong;
    end else begin
      unique case (state_q)
        httok_pkg::StFirst: begin
          fk = resp_mode_i ? httok_pkg::FkVersion : httok_pkg::FkMethod;
          if (data_byte_i == httok_pkg::ChSpace) begin
            if (!resp_mode_i && (mmis_q || midx_q != httok_pkg::MethodLen)) begin
              do_fail = 1'b1;
              fail_code = httok_pkg::FcBadMethod;
            end else begin
              do_close = 1'b1;
              close_next = httok_pkg::StSecond;
            end
          end else begin
            do_buf = 1'b1;
          end
        end
        httok_pkg::StSecond: begin
          fk = resp_mode_i ? httok_pkg::FkStatus : httok_pkg::FkPath;
          if (data_byte_i == httok_pkg::ChSpace) begin
            if (!resp_mode_i && !started_q) begin
              do_fail = 1'b1;
              fail_code = httok_pkg::FcEmptyPath;
            end else begin
              do_close = 1'b1;
              close_next = httok_pkg::StThirdR;
            end
          end else begin
            do_buf = 1'b1;
          end
        end
        httok_pkg::StThirdR: begin
          fk = resp_mode_i ? httok_pkg::FkText : httok_pkg::FkVersion;
          if (data_byte_i == httok_pkg::ChCr) begin
            do_close = 1'b1;
            close_next = httok_pkg::StThirdN;
          end else begin
            do_buf = 1'b1;
          end
        end
        httok_pkg::StThirdN, httok_pkg::StValueN: begin
          if (data_byte_i == httok_pkg::ChLf) begin
            state_d = httok_pkg::StKey;
          end else begin
            do_fail = 1'b1;
            fail_code = httok_pkg::FcLineEnd;
          end
        end
        httok_pkg::StKey: begin
          if (data_byte_i == httok_pkg::ChColon) begin
            fk = httok_pkg::FkKey;
            do_close = 1'b1;
            close_next = httok_pkg::StValueR;
          end else if (data_byte_i == httok_pkg::ChCr) begin
            state_d = httok_pkg::StEndR;
          end else begin
            fk = httok_pkg::FkKey;
            do_buf = 1'b1;
          end
        end
        httok_pkg::StValueR: begin
          fk = httok_pkg::FkValue;
          if (data_byte_i == httok_pkg::ChCr) begin
            do_close = 1'b1;
            close_next = httok_pkg::StValueN;
          end else begin
            do_buf = 1'b1;
          end
        end
        default: begin
          // closing line: only LF may follow the CR
          if (data_byte_i == httok_pkg::ChLf) begin
            state_d = httok_pkg::StBody;
            oc = httok_pkg::OcDone;
          end else begin
            do_fail = 1'b1;
            fail_code = httok_pkg::FcLineEnd;
          end
        end
      endcase
      if (do_close) begin
        state_d = close_next;
      end
    end
    if (do_fail) begin
      oc = httok_pkg::OcFailed;
      fk = httok_pkg::FkNone;
    end
  end

  // Field bookkeeping and failure flag
  always_comb begin
    len_d = len_q;
    started_d = started_q;
    midx_d = midx_q;
    mmis_d = mmis_q;
    acc_d = acc_q;
    digdone_d = digdone_q;
    failed_d = failed_q;
    cause_d = cause_q;
    if (kind_i || do_close) begin
      len_d = 8'd0;
      started_d = 1'b0;
      midx_d = 3'd0;
      mmis_d = 1'b0;
      acc_d = 16'd0;
      digdone_d = 1'b0;
    end
    if (kind_i) begin
      failed_d = 1'b0;
      cause_d = httok_pkg::FcNone;
    end
    if (do_fail) begin
      failed_d = 1'b1;
      cause_d = fail_code;
    end
    if (do_buf) begin
      if (len_q != 8'hFF) begin
        len_d = len_q + 8'd1;
      end
      if (data_byte_i != httok_pkg::ChSpace) begin
        started_d = 1'b1;
      end
      // method match only counts in the first field
      if (state_q == httok_pkg::StFirst) begin
        if (midx_q < httok_pkg::MethodLen && data_byte_i == httok_pkg::post_char(midx_q[1:0]))
        begin
          midx_d = midx_q + 3'd1;
        end else begin
          mmis_d = 1'b1;
        end
      end
      // decimal status accumulation, saturating
      if (state_q == httok_pkg::StSecond && !digdone_q) begin
        if (is_digit) begin
          acc_d = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
        end else begin
          digdone_d = 1'b1;
        end
      end
    end
  end

  // Result of this byte
  always_comb begin
    res_o.echo_byte = data_byte_i;
    res_o.byte_kept = do_buf && started_d;
    res_o.field_kind = fk;
    res_o.field_end = do_close;
    res_o.status_code = (do_close && state_q == httok_pkg::StSecond && resp_mode_i) ?
                        acc_q : 16'd0;
    res_o.outcome = oc;
    res_o.fail_cause = (oc == httok_pkg::OcFailed) ? cause_d : httok_pkg::FcNone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= httok_pkg::StFirst;
      len_q <= 8'd0;
      started_q <= 1'b0;
      midx_q <= 3'd0;
      mmis_q <= 1'b0;
      acc_q <= 16'd0;
      digdone_q <= 1'b0;
      failed_q <= 1'b0;
      cause_q <= httok_pkg::FcNone;
    end else if (acc_i) begin
      state_q <= state_d;
      len_q <= len_d;
      started_q <= started_d;
      midx_q <= midx_d;
      mmis_q <= mmis_d;
      acc_q <= acc_d;
      digdone_q <= digdone_d;
      failed_q <= failed_d;
      cause_q <= cause_d;
    end
  end

endmodule

>>> rtl/http_header_tokenizer_unit.sv
// HTTP header tokenizer, top level: config registers, parser, output buffering.
// Depends on httok_pkg, httok_parser and http_header_tokenizer_unit_defines.svh.
//
// Use: bytes of an HTTP/1.x message enter on the input channel (in_valid_i,
// in_stall_o, kind_i, data_byte_i); kind_i high restarts parsing. Every item
// gives exactly one result item on the output channel (out_valid_o,
// out_stall_i, echo_byte_o and the tag fields).
// Throughput: one item per cycle while in_stall_o is low; the parser state
// update is combinational logic between the parse state registers and the
// output register. When the receiver stalls, one further item is held in a
// skid register; in_stall_o rises only when that register is full, and
// results come out in order with nothing lost. Configuration (response mode,
// field length limit) is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the
// user must do so only while the block is idle; the block does not enforce it.
// Reset clears the parse state, the buffers and sets the registers to request
// mode with a field length limit of MaxLenInit (128 by default).
`include "http_header_tokenizer_unit_defines.svh"

module http_header_tokenizer_unit #(
  parameter logic [7:0] MaxLenInit = httok_pkg::MaxLenReset
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  echo_byte_o,
  output logic        byte_kept_o,
  output logic [2:0]  field_kind_o,
  output logic        field_end_o,
  output logic [15:0] status_code_o,
  output logic [1:0]  outcome_o,
  output logic [2:0]  fail_cause_o
);

  logic            resp_mode_q;
  logic [7:0]      max_len_q;
  logic            acc;
  logic            take;
  httok_pkg::res_t res_new;
  httok_pkg::res_t out_q;
  httok_pkg::res_t skid_q;
  logic            out_valid_q;
  logic            skid_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_mode_q <= 1'b0;
      max_len_q <= MaxLenInit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        httok_pkg::CfgRespMode: resp_mode_q <= cfg_wdata_i[0];
        default:                max_len_q <= cfg_wdata_i;
      endcase
    end
  end

  assign acc = in_valid_i && !skid_valid_q;
  assign take = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  httok_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .resp_mode_i (resp_mode_q),
    .max_len_i   (max_len_q),
    .res_o       (res_new)
  );

  // Output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || take) begin
        out_valid_q <= skid_valid_q || acc;
        skid_valid_q <= 1'b0;
      end else if (acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (acc) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign echo_byte_o = out_q.echo_byte;
  assign byte_kept_o = out_q.byte_kept;
  assign field_kind_o = out_q.field_kind;
  assign field_end_o = out_q.field_end;
  assign status_code_o = out_q.status_code;
  assign outcome_o = out_q.outcome;
  assign fail_cause_o = out_q.fail_cause;

  // Checks
  `HTTOK_ASSERT_NOW(a_skid_needs_out, skid_valid_q, out_valid_q)
  `HTTOK_ASSERT_NOW(a_cause_only_failed, out_valid_q && outcome_o != httok_pkg::OcFailed, fail_cause_o == httok_pkg::FcNone)
  `HTTOK_ASSERT_NOW(a_end_has_kind, out_valid_q && field_end_o, field_kind_o != httok_pkg::FkNone)
  `HTTOK_ASSERT_NEXT(a_stall_fills_skid, acc && out_valid_q && out_stall_i, skid_valid_q)

endmodule
